// ===== src/mfpu_pkg.sv =====
// Package for the minifloat pack/unpack core: float32 field constants,
// operation and configuration register codes. No dependencies.
`default_nettype none

package mfpu_pkg;

    localparam int unsigned F32_BIAS      = 127;
    localparam int unsigned F32_MANT_BITS = 23;
    localparam logic [7:0]  F32_EXP_ONES  = 8'hff;
    localparam logic [22:0] F32_MANT_MASK = 23'h7fffff;

    localparam int unsigned DATA_WIDTH     = 32;
    localparam int unsigned CFG_IDX_WIDTH  = 2;
    localparam int unsigned CFG_DATA_WIDTH = 5;

    typedef enum logic
    {
        OP_PACK   = 1'b0,
        OP_UNPACK = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0]
    {
        CFG_SIGN_WIDTH     = 2'd0,
        CFG_EXPONENT_WIDTH = 2'd1,
        CFG_MANTISSA_WIDTH = 2'd2
    } cfg_index_t;

endpackage

`default_nettype wire

// ===== src/minifloat_pack_unpack_core.sv =====
// Minifloat pack/unpack core: converts float32 bit patterns to and from a
// configurable small float format. Depends on mfpu_pkg.
//
// Usage:
//   s_axis: one word per transfer. tdata is the value, tuser the operation
//   (0 pack float32 into the small format, 1 unpack to float32).
//   m_axis: one result word per accepted input, in order.
//   cfg: write channel, cfg_index selects sign_width (0), exponent_width (1)
//   or mantissa_width (2); other indexes are ignored. Always ready. Write
//   only while no item is in flight.
//   Pipeline: a result passes through the input register, the conversion
//   logic and the result register.
//   Throughput: one item per cycle while the result register is empty or
//   being drained; a new input is taken whenever the input register is
//   empty or the result register is empty or being drained.
//   Reset: clears both pipeline valids and loads the register defaults
//   (sign 1, exponent 5, mantissa 10).
//   Stall: when m_axis_tready is low with a result waiting, the result
//   register holds and s_axis_tready drops only if the input register is also full.
`default_nettype none

module minifloat_pack_unpack_core
    import mfpu_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire logic [DATA_WIDTH-1:0]     s_axis_tdata,   // [31:0] value
    input  wire logic                      s_axis_tuser,   // [0] operation
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    output logic [DATA_WIDTH-1:0]          m_axis_tdata,   // [31:0] result
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data
);

    logic       sign_width_reg;
    logic [3:0] exponent_width_reg;
    logic [4:0] mantissa_width_reg;

    logic                  in_valid_reg;
    op_t                   op_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] result_reg;
    logic [DATA_WIDTH-1:0] result_next;
    logic                  advance;

    assign cfg_ready     = 1'b1;
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sign_width_reg     <= 1'b1;
            exponent_width_reg <= 4'd5;
            mantissa_width_reg <= 5'd10;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SIGN_WIDTH:     sign_width_reg     <= cfg_data[0];
                CFG_EXPONENT_WIDTH: exponent_width_reg <= cfg_data[3:0];
                CFG_MANTISSA_WIDTH: mantissa_width_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            op_reg    <= op_t'(s_axis_tuser);
            value_reg <= s_axis_tdata;
        end
        if (advance && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    // Effective format widths and derived constants
    logic [3:0]  ew;
    logic [4:0]  mw;
    logic [5:0]  sign_pos;
    logic [4:0]  mant_shift;
    logic [7:0]  maxe;
    logic [6:0]  bias;
    logic [22:0] mant_mask;

    always_comb
    begin
        if (exponent_width_reg == 4'd0)
            ew = 4'd1;
        else if (exponent_width_reg > 4'd8)
            ew = 4'd8;
        else
            ew = exponent_width_reg;
        mw         = (mantissa_width_reg > 5'd23) ? 5'd23 : mantissa_width_reg;
        sign_pos   = {2'b0, ew} + {1'b0, mw};
        mant_shift = 5'(F32_MANT_BITS) - mw;
        maxe       = ~(8'hff << ew);
        bias       = maxe[7:1];
        mant_mask  = ~(F32_MANT_MASK << mw);
    end

    // Pack
    logic        s_p;
    logic [7:0]  e_p;
    logic [22:0] m_p;
    logic [22:0] mant_p;
    logic [7:0]  ex_p;
    logic [9:0]  x_p;
    logic [DATA_WIDTH-1:0] word_p;

    always_comb
    begin
        s_p = value_reg[31];
        e_p = value_reg[30:23];
        m_p = value_reg[22:0];
        // Unsigned format: drop negatives to zero, but keep NaN payloads
        if (!sign_width_reg && s_p && !(e_p == F32_EXP_ONES && m_p != 23'd0))
        begin
            s_p = 1'b0;
            e_p = 8'd0;
            m_p = 23'd0;
        end
        mant_p = m_p >> mant_shift;
        x_p    = {2'b0, e_p} - 10'(F32_BIAS) + {3'b0, bias};
        if (e_p == 8'd0)
        begin
            ex_p = 8'd0;
        end
        else if (e_p == F32_EXP_ONES)
        begin
            ex_p = maxe;
        end
        else
        begin
            // Clamp below first, then above; exponent width 1 hits both
            if ($signed(x_p) < 10'sd1)
            begin
                x_p    = 10'd1;
                mant_p = 23'd0;
            end
            if ($signed(x_p) > $signed({2'b0, maxe} - 10'd1))
            begin
                x_p    = {2'b0, maxe} - 10'd1;
                mant_p = F32_MANT_MASK;
            end
            ex_p = x_p[7:0];
        end
        word_p = {9'b0, mant_p & mant_mask}
               | ({24'b0, ex_p & maxe} << mw)
               | ({31'b0, s_p & sign_width_reg} << sign_pos);
    end

    // Unpack
    logic [22:0] mant_u;
    logic [7:0]  ex_u;
    logic        s_u;
    logic [7:0]  fe_u;
    logic [DATA_WIDTH-1:0] shifted_u;
    logic [DATA_WIDTH-1:0] sign_word_u;
    logic [22:0] mant_out_u;

    always_comb
    begin
        mant_u      = value_reg[22:0] & mant_mask;
        shifted_u   = value_reg >> mw;
        ex_u        = shifted_u[7:0] & maxe;
        sign_word_u = value_reg >> sign_pos;
        s_u         = sign_width_reg & sign_word_u[0];
        if (ex_u == 8'd0)
            fe_u = 8'd0;
        else if (ex_u == maxe)
            fe_u = F32_EXP_ONES;
        else
            fe_u = ex_u - {1'b0, bias} + 8'(F32_BIAS);
        mant_out_u = mant_u << mant_shift;
    end

    always_comb
    begin
        unique case (op_reg)
            OP_PACK:   result_next = word_p;
            OP_UNPACK: result_next = {s_u, fe_u, mant_out_u};
            default:   result_next = word_p;
        endcase
    end

    // Checks
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready while result register is empty");

    a_accept_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_valid_reg)
        else $error("input transfer lost before input register");

    a_input_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && advance) |=> m_axis_tvalid)
        else $error("item in input register did not reach result register");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for minifloat_pack_unpack_core: drives pack/unpack words
// through the stream ports and checks each result against a local model.
// Depends on mfpu_pkg and the core.
`timescale 1ns / 1ps

module tb_top;
    import mfpu_pkg::*;

    localparam int               CYCLE_LIMIT  = 200000;
    localparam int               HOLD_CYCLES  = 120;
    localparam int               PHASE_ITEMS  = 175;
    localparam int               PHASE_COUNT  = 10;
    localparam logic [CFG_IDX_WIDTH-1:0] UNUSED_INDEX = 2'd3;

    // Model of the converter with its own copy of the format registers.
    class format_scoreboard;
        logic        sign_w;
        logic [3:0]  exp_w;
        logic [4:0]  mant_w;
        logic [31:0] expected_words[$];
        int          errors;

        function new();
            sign_w = 1'b1;
            exp_w  = 4'd5;
            mant_w = 5'd10;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_WIDTH-1:0] idx,
                                   logic [CFG_DATA_WIDTH-1:0] data);
            case (idx)
                CFG_SIGN_WIDTH:     sign_w = data[0];
                CFG_EXPONENT_WIDTH: exp_w  = data[3:0];
                CFG_MANTISSA_WIDTH: mant_w = data;
                default: ;
            endcase
        endfunction

        // Clamp the stored widths to what the format can hold.
        function void format_widths(output int unsigned ew, output int unsigned mw);
            ew = (exp_w == 4'd0) ? 1 : (exp_w > 4'd8) ? 8 : exp_w;
            mw = (mant_w > 5'd23) ? 23 : mant_w;
        endfunction

        function logic [31:0] to_minifloat(logic [31:0] v);
            int unsigned ew, mw, maxe, bias, mant, ex;
            int          x;
            logic        s;
            logic [7:0]  e;
            logic [22:0] m;
            logic [31:0] word;
            format_widths(ew, mw);
            maxe = (1 << ew) - 1;
            bias = maxe >> 1;
            s = v[31];
            e = v[30:23];
            m = v[22:0];
            // unsigned format: negative non-NaN collapses to +0
            if (!sign_w && s && !(e == F32_EXP_ONES && m != 23'd0))
            begin
                s = 1'b0;
                e = 8'd0;
                m = 23'd0;
            end
            mant = m >> (F32_MANT_BITS - mw);
            if (e == 8'd0)
                ex = 0;
            else if (e == F32_EXP_ONES)
                ex = maxe;
            else
            begin
                x = int'(e) - int'(F32_BIAS) + int'(bias);
                if (x < 1)
                begin
                    x = 1;
                    mant = 0;
                end
                if (x > int'(maxe) - 1)
                begin
                    x = int'(maxe) - 1;
                    mant = F32_MANT_MASK;
                end
                ex = x;
            end
            word = mant & ((1 << mw) - 1);
            word |= (ex & maxe) << mw;
            if (sign_w)
                word |= 32'(s) << (mw + ew);
            return word;
        endfunction

        function logic [31:0] to_float32(logic [31:0] v);
            int unsigned ew, mw, maxe, bias, mant, ex;
            logic        s;
            logic [7:0]  fe;
            format_widths(ew, mw);
            maxe = (1 << ew) - 1;
            bias = maxe >> 1;
            mant = v & ((1 << mw) - 1);
            ex = (v >> mw) & maxe;
            s = sign_w ? v[mw + ew] : 1'b0;
            if (ex == 0)
                fe = 8'd0;
            else if (ex == maxe)
                fe = F32_EXP_ONES;
            else
                fe = 8'(ex - bias + F32_BIAS);
            return {s, fe, 23'(mant << (F32_MANT_BITS - mw))};
        endfunction

        function void note_transfer(logic op, logic [31:0] value);
            if (op == OP_UNPACK)
                expected_words.push_back(to_float32(value));
            else
                expected_words.push_back(to_minifloat(value));
        endfunction

        function void check_word(logic [31:0] got);
            logic [31:0] want;
            if (expected_words.size() == 0)
            begin
                $display("[%0t] result with nothing expected: expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got !== want)
            begin
                $display("[%0t] result mismatch: expected %h, actual %h", $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [DATA_WIDTH-1:0]     s_axis_tdata  = '0;   // [31:0] value
    logic                      s_axis_tuser  = 1'b0; // [0] operation
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [DATA_WIDTH-1:0]     m_axis_tdata;         // [31:0] result
    logic                      cfg_valid     = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index     = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data      = '0;

    int   src_idle_pct  = 0;
    int   sink_idle_pct = 0;
    logic hold_req      = 1'b0;
    int   hold_left     = 0;
    int   cycle_count   = 0;

    format_scoreboard chk = new();

    minifloat_pack_unpack_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** minifloat_pack_unpack_core: FAILED **");
            $finish;
        end
    end

    // Watch all three channels at the edge, before any driver update lands.
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            chk.set_register(cfg_index, cfg_data);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            chk.note_transfer(s_axis_tuser, s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            chk.check_word(m_axis_tdata);
    end

    // Result side: random back-pressure, or a long hold when requested.
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req <= 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    task automatic send_item(op_t op, logic [31:0] value);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Stop offering input and wait until every result is back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (chk.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        // drop valid for a cycle so back-to-back writes never collide
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_format(logic sign, logic [4:0] expo, logic [4:0] mant);
        drain();
        write_config(CFG_SIGN_WIDTH, {4'd0, sign});
        write_config(CFG_EXPONENT_WIDTH, expo);
        write_config(CFG_MANTISSA_WIDTH, mant);
    endtask

    function automatic logic [31:0] pick_float();
        logic [7:0]  e;
        logic [22:0] m;
        case ($urandom_range(0, 5))
            0: e = 8'd0;
            1: e = F32_EXP_ONES;
            2, 3: e = 8'(107 + $urandom_range(0, 40));  // near the rebias window
            default: e = 8'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: m = 23'd0;
            1: m = F32_MANT_MASK;
            default: m = 23'($urandom);
        endcase
        return {1'($urandom), e, m};
    endfunction

    function automatic logic [31:0] pick_packed();
        int unsigned ew, mw;
        logic [31:0] w, emask;
        chk.format_widths(ew, mw);
        w = $urandom;
        emask = ((32'd1 << ew) - 1) << mw;
        case ($urandom_range(0, 3))
            0: w &= ~emask;
            1: w |= emask;
            default: ;
        endcase
        // mostly keep the bits above the format clear
        if ($urandom_range(0, 2) != 0)
            w &= (32'd1 << (mw + ew + chk.sign_w)) - 1;
        return w;
    endfunction

    initial
    begin
        op_t         op;
        logic [31:0] value;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // half-precision layout after reset
        send_item(OP_PACK,   32'h0000_0000);
        send_item(OP_PACK,   32'h8000_0000);
        send_item(OP_PACK,   32'h7f80_0000);
        send_item(OP_PACK,   32'h7fc0_0001);
        send_item(OP_PACK,   32'h3f80_0000);
        send_item(OP_PACK,   32'h7f7f_ffff);
        send_item(OP_PACK,   32'h0080_0000);
        send_item(OP_PACK,   32'h807f_ffff);
        send_item(OP_PACK,   32'h3380_0000);  // underflow
        send_item(OP_PACK,   32'h4780_0000);  // overflow
        send_item(OP_PACK,   32'hffff_ffff);
        send_item(OP_UNPACK, 32'h0000_0000);
        send_item(OP_UNPACK, 32'h0000_fc00);
        send_item(OP_UNPACK, 32'h0000_7bff);
        send_item(OP_UNPACK, 32'hfffe_0401);  // junk above the format

        // unsigned, exponent width 0 and mantissa width beyond 23
        set_format(1'b0, 5'd0, 5'd31);
        send_item(OP_PACK,   32'h8000_0000);
        send_item(OP_PACK,   32'hff80_0000);
        send_item(OP_PACK,   32'hffc0_0001);
        send_item(OP_PACK,   32'hbf80_0000);
        send_item(OP_PACK,   32'h3f80_0000);
        send_item(OP_UNPACK, 32'hffff_ffff);

        // exponent width above 8
        set_format(1'b1, 5'd15, 5'd24);
        send_item(OP_PACK,   32'hc049_0fdb);
        send_item(OP_UNPACK, 32'hffff_ffff);
        send_item(OP_UNPACK, 32'h3f80_0000);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: set_format(1'b1, 5'd5, 5'd10);
                1: set_format(1'b0, 5'd1, 5'd0);
                2: set_format(1'b1, 5'd8, 5'd23);
                3: set_format(1'b0, 5'd8, 5'd23);
                4: set_format(1'b1, 5'd1, 5'd23);
                5:
                begin
                    set_format(1'b1, 5'd4, 5'd3);
                    write_config(UNUSED_INDEX, 5'($urandom));
                end
                6: set_format(1'b0, 5'd20, 5'd2);
                7: set_format(1'b1, 5'd8, 5'd7);
                default: set_format(1'($urandom), 5'($urandom), 5'($urandom));
            endcase
            src_idle_pct  <= (p < 4) ? 27 : (p < 7) ? 66 : 0;
            sink_idle_pct <= (p < 4) ? 66 : (p < 7) ? 27 : 0;
            // long result-side hold while input keeps coming
            if (p == 2 || p == 8)
                hold_req <= 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                op = op_t'($urandom_range(0, 1));
                if ($urandom_range(0, 3) == 0)
                    value = $urandom;
                else if (op == OP_PACK)
                    value = pick_float();
                else
                    value = pick_packed();
                send_item(op, value);
            end
        end

        drain();
        if (chk.errors == 0 && chk.pending() == 0)
            $display("** minifloat_pack_unpack_core: PASSED **");
        else
            $display("** minifloat_pack_unpack_core: FAILED **");
        $finish;
    end

endmodule
